@@ hdl/midpoint_ellipse_rasterizer_core_macros.svh @@
// Assertion macros for the midpoint ellipse rasterizer checker.
// Expects clk and arst_n in the scope of each use.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH

// consequent checked in the same cycle
`define MER_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define MER_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/mer_pkg.sv @@
// Package for the midpoint ellipse rasterizer: default sizes, request codes,
// sequencer state, shared-unit operation codes and the control/status structs.
`timescale 1ns / 1ps

package mer_pkg;

	localparam int COORD_BITS_DEF  = 11;
	localparam int RADIUS_BITS_DEF = 10;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef enum logic [4:0] {
		S_WAIT,
		S_I1, S_I2, S_I3, S_I4,
		S_CHK,
		S_E0, S_E1, S_E2, S_E3, S_E4, S_E5,
		S_A0, S_A1, S_A2, S_A3, S_A4,
		S_B0, S_B1, S_B2, S_B3, S_B4
	} seq_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DEC_INIT,
		OP_DEC_ADD_RX2,
		OP_DEC_LOAD_P,
		OP_DEC_ADD_4P,
		OP_DEC_SUB_4P,
		OP_DEC_ADD_4SX,
		OP_DEC_SUB_4SY,
		OP_DEC_ADD_4RY2,
		OP_DEC_ADD_4RX2,
		OP_SX_ADD,
		OP_SY_SUB
	} add_op_t;

	typedef enum logic [2:0] {
		MS_T_T,
		MS_IN_RX,
		MS_RX2_T,
		MS_TX_TX,
		MS_YM_YM,
		MS_RY2_T,
		MS_RX2_RY2
	} mul_sel_t;

	typedef struct packed {
		logic acc_start;
		logic acc_r1;
		logic acc_r2;
		logic flag;
		logic r1_done;
	} seq_stat_t;

	typedef struct packed {
		add_op_t  op;
		mul_sel_t mul_sel;
		logic     ld_rx2;
		logic     ld_ry2;
		logic     ld_sy;
		logic     ld_t;
		logic     x_inc;
		logic     y_dec;
		logic     set_reg2;
		logic     flag_r1;
		logic     flag_r2;
		logic     wait_st;
	} seq_ctrl_t;

endpackage

@@ hdl/mer_if.sv @@
// Request and response channel interfaces of the ellipse rasterizer.
// Depends on mer_pkg for default sizes.
`timescale 1ns / 1ps

interface mer_in_if #(
	parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [COORD_BITS-1:0]  center_x;
	logic [COORD_BITS-1:0]  center_y;
	logic [RADIUS_BITS-1:0] radius_x;
	logic [RADIUS_BITS-1:0] radius_y;

	modport source (output valid, req_type, center_x, center_y, radius_x, radius_y,
		input ready);
	modport sink (input valid, req_type, center_x, center_y, radius_x, radius_y,
		output ready);
endinterface

interface mer_out_if #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [COORD_BITS+1:0] col_plus;
	logic signed [COORD_BITS+1:0] col_minus;
	logic signed [COORD_BITS+1:0] row_plus;
	logic signed [COORD_BITS+1:0] row_minus;
	logic                        in_region_two;
	logic                        last_point;

	modport source (output valid, col_plus, col_minus, row_plus, row_minus,
		in_region_two, last_point, input ready);
	modport sink (input valid, col_plus, col_minus, row_plus, row_minus,
		in_region_two, last_point, output ready);
endinterface

@@ hdl/mer_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Standalone; operands are selected by the core.
`timescale 1ns / 1ps

module mer_mul #(
	parameter int A_W = 24
) (
	input  logic             clk,
	input  logic [A_W-1:0]   a,
	input  logic [A_W-1:0]   b,
	output logic [2*A_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

@@ hdl/mer_seq.sv @@
// Sequencer of the ellipse rasterizer: steps the shared adder and multiplier.
// Depends on mer_pkg for state, operation codes and control structs.
`timescale 1ns / 1ps

module mer_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  mer_pkg::seq_stat_t  stat,
	output mer_pkg::seq_ctrl_t  ctrl
);

	mer_pkg::seq_state_t state_q;
	mer_pkg::seq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::S_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mer_pkg::S_WAIT: begin
				if (stat.acc_start) begin
					state_d = mer_pkg::S_I1;
				end else if (stat.acc_r1) begin
					state_d = mer_pkg::S_A0;
				end else if (stat.acc_r2) begin
					state_d = mer_pkg::S_B0;
				end
			end
			mer_pkg::S_I1: state_d = mer_pkg::S_I2;
			mer_pkg::S_I2: state_d = mer_pkg::S_I3;
			mer_pkg::S_I3: state_d = mer_pkg::S_I4;
			mer_pkg::S_I4: state_d = mer_pkg::S_CHK;
			mer_pkg::S_CHK: state_d = stat.r1_done ? mer_pkg::S_E0 : mer_pkg::S_WAIT;
			mer_pkg::S_E0: state_d = mer_pkg::S_E1;
			mer_pkg::S_E1: state_d = mer_pkg::S_E2;
			mer_pkg::S_E2: state_d = mer_pkg::S_E3;
			mer_pkg::S_E3: state_d = mer_pkg::S_E4;
			mer_pkg::S_E4: state_d = mer_pkg::S_E5;
			mer_pkg::S_E5: state_d = mer_pkg::S_WAIT;
			mer_pkg::S_A0: state_d = mer_pkg::S_A1;
			mer_pkg::S_A1: state_d = mer_pkg::S_A2;
			mer_pkg::S_A2: state_d = stat.flag ? mer_pkg::S_CHK : mer_pkg::S_A3;
			mer_pkg::S_A3: state_d = mer_pkg::S_A4;
			mer_pkg::S_A4: state_d = mer_pkg::S_CHK;
			mer_pkg::S_B0: state_d = mer_pkg::S_B1;
			mer_pkg::S_B1: state_d = mer_pkg::S_B2;
			mer_pkg::S_B2: state_d = stat.flag ? mer_pkg::S_WAIT : mer_pkg::S_B3;
			mer_pkg::S_B3: state_d = mer_pkg::S_B4;
			mer_pkg::S_B4: state_d = mer_pkg::S_WAIT;
			default: state_d = mer_pkg::S_WAIT;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.op = mer_pkg::OP_NONE;
		ctrl.mul_sel = mer_pkg::MS_T_T;
		unique case (state_q)
			mer_pkg::S_WAIT: begin
				ctrl.wait_st = 1'b1;
				if (stat.acc_start) begin
					ctrl.mul_sel = mer_pkg::MS_IN_RX;
				end
			end
			mer_pkg::S_I1: begin
				ctrl.ld_rx2 = 1'b1;
				ctrl.mul_sel = mer_pkg::MS_T_T;
			end
			mer_pkg::S_I2: begin
				ctrl.ld_ry2 = 1'b1;
				ctrl.mul_sel = mer_pkg::MS_RX2_T;
			end
			mer_pkg::S_I3: begin
				ctrl.ld_sy = 1'b1;
				ctrl.op = mer_pkg::OP_DEC_INIT;
			end
			mer_pkg::S_I4: ctrl.op = mer_pkg::OP_DEC_ADD_RX2;
			mer_pkg::S_CHK: ;
			mer_pkg::S_E0: ctrl.mul_sel = mer_pkg::MS_TX_TX;
			mer_pkg::S_E1: begin
				ctrl.ld_t = 1'b1;
				ctrl.mul_sel = mer_pkg::MS_YM_YM;
			end
			mer_pkg::S_E2: begin
				ctrl.ld_t = 1'b1;
				ctrl.mul_sel = mer_pkg::MS_RY2_T;
			end
			mer_pkg::S_E3: begin
				ctrl.op = mer_pkg::OP_DEC_LOAD_P;
				ctrl.mul_sel = mer_pkg::MS_RX2_T;
			end
			mer_pkg::S_E4: begin
				ctrl.op = mer_pkg::OP_DEC_ADD_4P;
				ctrl.mul_sel = mer_pkg::MS_RX2_RY2;
			end
			mer_pkg::S_E5: begin
				ctrl.op = mer_pkg::OP_DEC_SUB_4P;
				ctrl.set_reg2 = 1'b1;
			end
			mer_pkg::S_A0: begin
				ctrl.op = mer_pkg::OP_SX_ADD;
				ctrl.x_inc = 1'b1;
				ctrl.flag_r1 = 1'b1;
			end
			mer_pkg::S_A1: begin
				if (stat.flag) begin
					ctrl.op = mer_pkg::OP_DEC_ADD_4SX;
				end else begin
					ctrl.op = mer_pkg::OP_SY_SUB;
					ctrl.y_dec = 1'b1;
				end
			end
			mer_pkg::S_A2: begin
				ctrl.op = stat.flag ? mer_pkg::OP_DEC_ADD_4RY2 : mer_pkg::OP_DEC_ADD_4SX;
			end
			mer_pkg::S_A3: ctrl.op = mer_pkg::OP_DEC_SUB_4SY;
			mer_pkg::S_A4: ctrl.op = mer_pkg::OP_DEC_ADD_4RY2;
			mer_pkg::S_B0: begin
				ctrl.op = mer_pkg::OP_SY_SUB;
				ctrl.y_dec = 1'b1;
				ctrl.flag_r2 = 1'b1;
			end
			mer_pkg::S_B1: begin
				if (stat.flag) begin
					ctrl.op = mer_pkg::OP_DEC_ADD_4RX2;
				end else begin
					ctrl.op = mer_pkg::OP_SX_ADD;
					ctrl.x_inc = 1'b1;
				end
			end
			mer_pkg::S_B2: begin
				ctrl.op = stat.flag ? mer_pkg::OP_DEC_SUB_4SY : mer_pkg::OP_DEC_ADD_4SX;
			end
			mer_pkg::S_B3: ctrl.op = mer_pkg::OP_DEC_SUB_4SY;
			mer_pkg::S_B4: ctrl.op = mer_pkg::OP_DEC_ADD_4RX2;
			default: ;
		endcase
	end

endmodule

@@ hdl/midpoint_ellipse_rasterizer_core.sv @@
// Midpoint ellipse rasterizer top level: decision registers, shared adder,
// output register. Depends on mer_pkg, mer_if, mer_mul and mer_seq.
`timescale 1ns / 1ps

// A start word loads centre and radii; states I1-I4 and CHK set up the
// decision terms, then E0-E5 if the ellipse opens in region 2 (a zero
// radius). Each step word then gives one point: in region 1 A0-A2 (and
// A3-A4 when y steps) then CHK, plus E0-E5 if the walk enters region 2;
// in region 2 B0-B2 (and B3-B4 when x steps); none for the final point.
// One shared 48-bit add/subtract unit does one update per cycle, and one
// shared registered multiplier the squared terms. Idle steps are dropped.
module midpoint_ellipse_rasterizer_core #(
	parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mer_in_if.sink     req,
	mer_out_if.source  rsp
);

	localparam int MUL_W = 2 * RADIUS_BITS + 4;
	localparam int DEC_W = 2 * MUL_W;
	localparam int SQ_W  = 2 * RADIUS_BITS;
	localparam int OUT_W = COORD_BITS + 2;

	mer_pkg::seq_stat_t stat;
	mer_pkg::seq_ctrl_t ctrl;

	logic [COORD_BITS-1:0]   cx_q, cy_q, x_q, y_q;
	logic [SQ_W-1:0]         rx2_q, ry2_q;
	logic [MUL_W-1:0]        t_q;
	logic signed [DEC_W-1:0] sx_q, sy_q, dec_q;
	logic                    busy_q, reg2_q, flag_q, out_vld_q;
	logic signed [OUT_W-1:0] col_plus_q, col_minus_q, row_plus_q, row_minus_q;
	logic                    irt_q, last_q;

	logic                    acc, step_live, y_zero;
	logic [COORD_BITS-1:0]   ym;
	logic [MUL_W-1:0]        mul_a, mul_b;
	logic [DEC_W-1:0]        prod;
	logic signed [DEC_W-1:0] add_a, add_b, add_y;
	logic                    add_sub;

	assign acc       = req.valid && req.ready;
	assign y_zero    = (y_q == '0);
	assign step_live = acc && (req.req_type == mer_pkg::REQ_STEP) && busy_q;

	assign stat.acc_start = acc && (req.req_type == mer_pkg::REQ_START);
	assign stat.acc_r1    = step_live && !reg2_q;
	assign stat.acc_r2    = step_live && reg2_q && !y_zero;
	assign stat.flag      = flag_q;
	assign stat.r1_done   = !(sx_q < sy_q);

	assign req.ready = ctrl.wait_st && (!out_vld_q || rsp.ready);

	mer_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign ym = y_zero ? COORD_BITS'(1) : y_q - COORD_BITS'(1);

	always_comb begin
		mul_a = t_q;
		mul_b = t_q;
		unique case (ctrl.mul_sel)
			mer_pkg::MS_T_T: begin
				mul_a = t_q;
				mul_b = t_q;
			end
			mer_pkg::MS_IN_RX: begin
				mul_a = MUL_W'(req.radius_x);
				mul_b = MUL_W'(req.radius_x);
			end
			mer_pkg::MS_RX2_T: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = t_q;
			end
			mer_pkg::MS_TX_TX: begin
				mul_a = MUL_W'({x_q, 1'b1});
				mul_b = MUL_W'({x_q, 1'b1});
			end
			mer_pkg::MS_YM_YM: begin
				mul_a = MUL_W'(ym);
				mul_b = MUL_W'(ym);
			end
			mer_pkg::MS_RY2_T: begin
				mul_a = MUL_W'(ry2_q);
				mul_b = t_q;
			end
			mer_pkg::MS_RX2_RY2: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = MUL_W'(ry2_q);
			end
			default: ;
		endcase
	end

	mer_mul #(
		.A_W (MUL_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	always_comb begin
		add_a   = dec_q;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (ctrl.op)
			mer_pkg::OP_NONE: ;
			mer_pkg::OP_DEC_INIT: begin
				add_a   = DEC_W'({ry2_q, 2'b00});
				add_b   = {prod[DEC_W-3:0], 2'b00};
				add_sub = 1'b1;
			end
			mer_pkg::OP_DEC_ADD_RX2: add_b = DEC_W'(rx2_q);
			mer_pkg::OP_DEC_LOAD_P:  add_a = prod;
			mer_pkg::OP_DEC_ADD_4P:  add_b = {prod[DEC_W-3:0], 2'b00};
			mer_pkg::OP_DEC_SUB_4P: begin
				add_b   = {prod[DEC_W-3:0], 2'b00};
				add_sub = 1'b1;
			end
			mer_pkg::OP_DEC_ADD_4SX: add_b = {sx_q[DEC_W-3:0], 2'b00};
			mer_pkg::OP_DEC_SUB_4SY: begin
				add_b   = {sy_q[DEC_W-3:0], 2'b00};
				add_sub = 1'b1;
			end
			mer_pkg::OP_DEC_ADD_4RY2: add_b = DEC_W'({ry2_q, 2'b00});
			mer_pkg::OP_DEC_ADD_4RX2: add_b = DEC_W'({rx2_q, 2'b00});
			mer_pkg::OP_SX_ADD: begin
				add_a = sx_q;
				add_b = DEC_W'({ry2_q, 1'b0});
			end
			mer_pkg::OP_SY_SUB: begin
				add_a   = sy_q;
				add_b   = DEC_W'({rx2_q, 1'b0});
				add_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign add_y = add_sub ? add_a - add_b : add_a + add_b;

	always_ff @(posedge clk) begin
		if (stat.acc_start) begin
			cx_q <= req.center_x;
			cy_q <= req.center_y;
			x_q  <= '0;
			y_q  <= COORD_BITS'(req.radius_y);
			t_q  <= MUL_W'(req.radius_y);
			sx_q <= '0;
		end else begin
			if (ctrl.x_inc) begin
				x_q <= x_q + COORD_BITS'(1);
			end
			if (ctrl.y_dec) begin
				y_q <= y_q - COORD_BITS'(1);
			end
			if (ctrl.ld_t) begin
				t_q <= prod[MUL_W-1:0];
			end
			case (ctrl.op) inside
				mer_pkg::OP_SX_ADD: sx_q <= add_y;
				mer_pkg::OP_SY_SUB: sy_q <= add_y;
				mer_pkg::OP_DEC_INIT, mer_pkg::OP_DEC_ADD_RX2, mer_pkg::OP_DEC_LOAD_P,
				mer_pkg::OP_DEC_ADD_4P, mer_pkg::OP_DEC_SUB_4P, mer_pkg::OP_DEC_ADD_4SX,
				mer_pkg::OP_DEC_SUB_4SY, mer_pkg::OP_DEC_ADD_4RY2,
				mer_pkg::OP_DEC_ADD_4RX2: dec_q <= add_y;
				default: ;
			endcase
			if (ctrl.ld_sy) begin
				sy_q <= {prod[DEC_W-2:0], 1'b0};
			end
		end
		if (ctrl.ld_rx2) begin
			rx2_q <= prod[SQ_W-1:0];
		end
		if (ctrl.ld_ry2) begin
			ry2_q <= prod[SQ_W-1:0];
		end
		if (ctrl.flag_r1) begin
			flag_q <= dec_q[DEC_W-1];
		end else if (ctrl.flag_r2) begin
			flag_q <= !dec_q[DEC_W-1] && (dec_q != '0);
		end
		if (step_live) begin
			col_plus_q  <= OUT_W'(cx_q) + OUT_W'(x_q);
			col_minus_q <= OUT_W'(cx_q) - OUT_W'(x_q);
			row_plus_q  <= OUT_W'(cy_q) + OUT_W'(y_q);
			row_minus_q <= OUT_W'(cy_q) - OUT_W'(y_q);
			irt_q       <= reg2_q;
			last_q      <= reg2_q && y_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			reg2_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (stat.acc_start) begin
				busy_q <= 1'b1;
				reg2_q <= 1'b0;
			end else begin
				if (step_live && reg2_q && y_zero) begin
					busy_q <= 1'b0;
				end
				if (ctrl.set_reg2) begin
					reg2_q <= 1'b1;
				end
			end
			if (step_live) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.col_plus      = col_plus_q;
	assign rsp.col_minus     = col_minus_q;
	assign rsp.row_plus      = row_plus_q;
	assign rsp.row_minus     = row_minus_q;
	assign rsp.in_region_two = irt_q;
	assign rsp.last_point    = last_q;

endmodule

@@ hdl/mer_checker.sv @@
// Port-level checker for the ellipse rasterizer, bound to the top level.
// Depends on mer_pkg, mer_if and the assertion macro header.
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_core_macros.svh"

module mer_checker (
	input logic       clk,
	input logic       arst_n,
	mer_in_if.sink    req,
	mer_out_if.source rsp
);

	`MER_ASSERT_NXT(a_start_busy, req.valid && req.ready && (req.req_type == mer_pkg::REQ_START), !req.ready, "request ready right after a start word")
	`MER_ASSERT_IMP(a_mirror_parity, rsp.valid, (rsp.col_plus[0] == rsp.col_minus[0]) && (rsp.row_plus[0] == rsp.row_minus[0]), "mirrored coordinates not symmetric about the centre")
	`MER_ASSERT_IMP(a_last_on_axis, rsp.valid && rsp.last_point, rsp.in_region_two && (rsp.row_plus == rsp.row_minus), "last point off the horizontal axis or outside region 2")
	`MER_ASSERT_NXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.col_plus) && $stable(rsp.row_minus), "stalled response word changed")

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_ellipse_rasterizer_core: a directed table, then random
// start/step words, each pixel compared with a table entry or an in-bench walk of the ellipse.
// Depends on mer_pkg, mer_if (mer_in_if, mer_out_if) and the core RTL.

module testbench;
	import mer_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int RB = RADIUS_BITS_DEF;
	localparam int PB = CB + 2;
	localparam int RANDOM_WORDS = 750;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT_PIXEL = 150;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic          kind;
		logic [CB-1:0] cx;
		logic [CB-1:0] cy;
		logic [RB-1:0] rx;
		logic [RB-1:0] ry;
	} ellipse_word_t;

	typedef struct packed {
		logic [PB-1:0] col_plus;
		logic [PB-1:0] col_minus;
		logic [PB-1:0] row_plus;
		logic [PB-1:0] row_minus;
		logic          in_r2;
		logic          last;
	} pixel_t;

	typedef enum logic [1:0] {FROM_WALK, NO_PIXEL, FIXED_PIXEL} pixel_src_t;

	typedef struct packed {
		ellipse_word_t word;
		pixel_src_t    src;
		pixel_t        px;
	} table_row_t;

	localparam pixel_t NONE_PX = '0;

	table_row_t directed_rows [25] = '{
		'{'{REQ_STEP,  11'd5,    11'd9,    10'd3,    10'd4},    NO_PIXEL,    NONE_PX},
		'{'{REQ_START, 11'd0,    11'd0,    10'd1,    10'd1},    NO_PIXEL,    NONE_PX},
		'{'{REQ_STEP,  11'd2047, 11'd2047, 10'd1023, 10'd1023}, FIXED_PIXEL,
			'{13'd0, 13'd0, 13'd1, 13'h1fff, 1'b0, 1'b0}},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    NO_PIXEL,    NONE_PX},
		'{'{REQ_START, 11'd2047, 11'd2047, 10'd1023, 10'd1023}, NO_PIXEL,    NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FIXED_PIXEL,
			'{13'd2047, 13'd2047, 13'd3070, 13'd1024, 1'b0, 1'b0}},
		'{'{REQ_STEP,  11'd1,    11'd2,    10'd3,    10'd4},    FROM_WALK,   NONE_PX},
		'{'{REQ_STEP,  11'd2047, 11'd0,    10'd1023, 10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_START, 11'd100,  11'd200,  10'd5,    10'd0},    NO_PIXEL,    NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FIXED_PIXEL,
			'{13'd100, 13'd100, 13'd200, 13'd200, 1'b1, 1'b1}},
		'{'{REQ_STEP,  11'd7,    11'd7,    10'd7,    10'd7},    NO_PIXEL,    NONE_PX},
		'{'{REQ_START, 11'd1024, 11'd0,    10'd0,    10'd3},    NO_PIXEL,    NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FIXED_PIXEL,
			'{13'd1024, 13'd1024, 13'd3, 13'h1ffd, 1'b1, 1'b0}},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_START, 11'd1500, 11'd700,  10'd0,    10'd0},    NO_PIXEL,    NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FIXED_PIXEL,
			'{13'd1500, 13'd1500, 13'd700, 13'd700, 1'b1, 1'b1}},
		'{'{REQ_START, 11'd1365, 11'd682,  10'd682,  10'd341},  NO_PIXEL,    NONE_PX},
		'{'{REQ_STEP,  11'd682,  11'd1365, 10'd341,  10'd682},  FROM_WALK,   NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_STEP,  11'd0,    11'd0,    10'd0,    10'd0},    FROM_WALK,   NONE_PX},
		'{'{REQ_START, 11'd0,    11'd2047, 10'd1023, 10'd1},    NO_PIXEL,    NONE_PX}
	};

	logic clk;
	logic arst_n;

	mer_in_if  req_bus ();
	mer_out_if pix_bus ();

	midpoint_ellipse_rasterizer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (pix_bus)
	);

	// walk state, mirrors the block
	logic          walk_busy;
	logic          walk_in_r2;
	logic [CB-1:0] walk_x;
	logic [CB-1:0] walk_y;
	logic [CB-1:0] walk_cx;
	logic [CB-1:0] walk_cy;
	longint        walk_sx;
	longint        walk_sy;
	longint        walk_dec;
	longint        walk_rx2;
	longint        walk_ry2;

	pixel_t pending_pixels [$];
	int     errors;
	int     pixels_seen;
	int     live_words;
	int     ellipses;
	int     burst_left;
	int     cycle_count;

	function automatic void begin_region_two();
		longint tx;
		longint ym;
		tx = 2 * longint'(walk_x) + 1;
		ym = longint'(walk_y) - 1;
		walk_in_r2 = 1'b1;
		walk_dec = walk_ry2 * tx * tx + 4 * walk_rx2 * ym * ym - 4 * walk_rx2 * walk_ry2;
	endfunction

	function automatic void walk_ellipse(input ellipse_word_t w, output bit has_px,
		output pixel_t px);
		longint ry;
		has_px = 1'b0;
		px = '0;
		if (w.kind == REQ_START) begin
			ry = longint'(w.ry);
			walk_cx = w.cx;
			walk_cy = w.cy;
			walk_rx2 = longint'(w.rx) * longint'(w.rx);
			walk_ry2 = ry * ry;
			walk_x = '0;
			walk_y = CB'(w.ry);
			walk_sx = 0;
			walk_sy = 2 * walk_rx2 * ry;
			walk_dec = 4 * walk_ry2 - 4 * walk_rx2 * ry + walk_rx2;
			walk_in_r2 = 1'b0;
			walk_busy = 1'b1;
			if (!(walk_sx < walk_sy))
				begin_region_two();
		end else if (walk_busy) begin
			has_px = 1'b1;
			px.col_plus = PB'(walk_cx) + PB'(walk_x);
			px.col_minus = PB'(walk_cx) - PB'(walk_x);
			px.row_plus = PB'(walk_cy) + PB'(walk_y);
			px.row_minus = PB'(walk_cy) - PB'(walk_y);
			px.in_r2 = walk_in_r2;
			px.last = 1'b0;
			if (!walk_in_r2) begin
				walk_x = walk_x + 1'b1;
				walk_sx = walk_sx + 2 * walk_ry2;
				if (walk_dec < 0) begin
					walk_dec = walk_dec + 4 * (walk_sx + walk_ry2);
				end else begin
					walk_y = walk_y - 1'b1;
					walk_sy = walk_sy - 2 * walk_rx2;
					walk_dec = walk_dec + 4 * (walk_sx - walk_sy + walk_ry2);
				end
				if (!(walk_sx < walk_sy))
					begin_region_two();
			end else if (walk_y == '0) begin
				px.last = 1'b1;
				walk_busy = 1'b0;
			end else begin
				walk_y = walk_y - 1'b1;
				walk_sy = walk_sy - 2 * walk_rx2;
				if (walk_dec > 0) begin
					walk_dec = walk_dec + 4 * (walk_rx2 - walk_sy);
				end else begin
					walk_x = walk_x + 1'b1;
					walk_sx = walk_sx + 2 * walk_ry2;
					walk_dec = walk_dec + 4 * (walk_sx - walk_sy + walk_rx2);
				end
			end
		end
	endfunction

	function automatic ellipse_word_t step_word();
		ellipse_word_t w;
		w.kind = REQ_STEP;
		w.cx = CB'($urandom_range(0, (1 << CB) - 1));
		w.cy = CB'($urandom_range(0, (1 << CB) - 1));
		w.rx = RB'($urandom_range(0, (1 << RB) - 1));
		w.ry = RB'($urandom_range(0, (1 << RB) - 1));
		return w;
	endfunction

	task automatic field_check(input string name, input logic [PB-1:0] want, got);
		if (got !== want) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
					$signed(want), $signed(got));
			errors++;
		end
	endtask

	task automatic check_pixel(input pixel_t got);
		pixel_t want;
		pixels_seen++;
		if (pending_pixels.size() == 0) begin
			if (errors < MAX_REPORTS)
				$display("%0t: unexpected pixel, expected none, actual col %0d/%0d row %0d/%0d",
					$time, $signed(got.col_plus), $signed(got.col_minus),
					$signed(got.row_plus), $signed(got.row_minus));
			errors++;
		end else begin
			want = pending_pixels.pop_front();
			field_check("col_plus", want.col_plus, got.col_plus);
			field_check("col_minus", want.col_minus, got.col_minus);
			field_check("row_plus", want.row_plus, got.row_plus);
			field_check("row_minus", want.row_minus, got.row_minus);
			field_check("in_region_two", PB'(want.in_r2), PB'(got.in_r2));
			field_check("last_point", PB'(want.last), PB'(got.last));
		end
	endtask

	task automatic send_word(input ellipse_word_t w, input pixel_src_t src,
		input pixel_t fixed_px);
		int     gap;
		bit     has_px;
		pixel_t px;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		req_bus.valid <= 1'b1;
		req_bus.req_type <= w.kind;
		req_bus.center_x <= w.cx;
		req_bus.center_y <= w.cy;
		req_bus.radius_x <= w.rx;
		req_bus.radius_y <= w.ry;
		@(posedge clk);
		while (req_bus.ready !== 1'b1)
			@(posedge clk);
		if (w.kind == REQ_START || walk_busy)
			live_words++;
		if (w.kind == REQ_START)
			ellipses++;
		walk_ellipse(w, has_px, px);
		if (src == FIXED_PIXEL)
			pending_pixels.push_back(fixed_px);
		else if (src == FROM_WALK && has_px)
			pending_pixels.push_back(px);
	endtask

	// hold input until every pixel is back
	task automatic wait_for_drain();
		req_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_pixels.size() != 0);
		burst_left = 0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int     run_left;
		int     hold_left;
		bit     run_ready;
		bit     held;
		pixel_t got;
		pix_bus.ready <= 1'b0;
		run_left = 0;
		hold_left = 0;
		run_ready = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) begin
				got = '{pix_bus.col_plus, pix_bus.col_minus, pix_bus.row_plus,
					pix_bus.row_minus, pix_bus.in_region_two, pix_bus.last_point};
				check_pixel(got);
			end
			if (!held && pixels_seen >= HOLD_AT_PIXEL) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_bus.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_ready = ($urandom_range(0, 9) < 7);
					run_left = run_ready ? $urandom_range(1, 30) : $urandom_range(1, 6);
				end
				run_left--;
				pix_bus.ready <= run_ready;
			end
		end
	end

	initial begin
		ellipse_word_t w;
		int            base;
		int            pick;
		int            cap;
		int            steps;
		bit            paused;
		req_bus.valid <= 1'b0;
		req_bus.req_type <= REQ_START;
		req_bus.center_x <= '0;
		req_bus.center_y <= '0;
		req_bus.radius_x <= '0;
		req_bus.radius_y <= '0;
		walk_busy = 1'b0;
		walk_in_r2 = 1'b0;
		walk_x = '0;
		walk_y = '0;
		walk_cx = '0;
		walk_cy = '0;
		walk_sx = 0;
		walk_sy = 0;
		walk_dec = 0;
		walk_rx2 = 0;
		walk_ry2 = 0;
		errors = 0;
		pixels_seen = 0;
		live_words = 0;
		ellipses = 0;
		burst_left = 0;
		paused = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].src, directed_rows[i].px);

		base = live_words;
		while (live_words - base < RANDOM_WORDS) begin
			if ($urandom_range(0, 99) < 8) begin
				w = step_word();
				w.kind = 1'($urandom_range(0, 1));
				send_word(w, FROM_WALK, NONE_PX);
			end
			w = step_word();
			w.kind = REQ_START;
			cap = 100000;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				w.rx = RB'($urandom_range(1, 24));
				w.ry = RB'($urandom_range(1, 24));
				if ($urandom_range(0, 6) == 0)
					cap = $urandom_range(1, 12);
			end else if (pick < 78) begin
				w.rx = ($urandom_range(0, 1) == 0) ? '0 : RB'($urandom_range(0, 40));
				w.ry = (w.rx == '0) ? RB'($urandom_range(0, 40)) : '0;
			end else if (pick < 90) begin
				cap = $urandom_range(2, 40);
			end else begin
				w.rx = RB'($urandom_range(25, 60));
				w.ry = RB'($urandom_range(25, 60));
			end
			send_word(w, FROM_WALK, NONE_PX);
			steps = 0;
			while (walk_busy && steps < cap) begin
				send_word(step_word(), FROM_WALK, NONE_PX);
				steps++;
			end
			repeat ($urandom_range(0, 2))
				send_word(step_word(), FROM_WALK, NONE_PX);
			if (!paused && live_words - base >= RANDOM_WORDS / 2) begin
				wait_for_drain();
				paused = 1'b1;
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d ellipse starts over %0d live words, %0d pixels compared.",
			ellipses, live_words, pixels_seen);
		$display("Included a %0d-cycle output hold-off and a full mid-run drain.", HOLD_CYCLES);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mer_pkg.sv
hdl/mer_if.sv
hdl/mer_mul.sv
hdl/mer_seq.sv
hdl/midpoint_ellipse_rasterizer_core.sv
hdl/mer_checker.sv
dv/testbench.sv
